### hw/rtl/lhe_pkg.sv
// ----------------------------------------------------------------------------
// lhe_pkg
// Types, codes and fixed widths shared by the latency histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lhe_pkg;

  localparam int VAL_W   = 12;
  localparam int KIND_W  = 3;
  localparam int PCT_W   = 14;
  localparam int RES_W   = 13;
  localparam int RCNT_W  = 32;
  localparam int TOTAL_W = 40;
  localparam int WSUM_W  = 52;
  localparam int RUN_W   = TOTAL_W + 1;
  localparam int PROD_W  = PCT_W + TOTAL_W;
  localparam int DCNT_W  = 3;

  // rank division by 10000: 16-bit digits, each by reciprocal multiplication
  localparam int DIG_W    = 16;
  localparam int DIVN_W   = 64;
  localparam int DIVX_W   = DIG_W + PCT_W;
  localparam int RECIP_W  = 31;
  localparam int RECIP_SH = 44;

  localparam logic [PCT_W-1:0]   PCT_FULL      = 14'd10000;
  localparam logic [RECIP_W-1:0] PCT_RECIP     = 31'd1759218605;
  localparam logic [DCNT_W-1:0]  DIV_LAST      = DCNT_W'(2 * DIVN_W / DIG_W - 1);
  localparam logic [VAL_W-1:0]   MAX_VALUE_RST = 12'hFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};
  localparam logic [WSUM_W-1:0]  WSUM_MAX      = {WSUM_W{1'b1}};
  localparam logic [RCNT_W-1:0]  RCNT_MAX      = {RCNT_W{1'b1}};

  // register byte addresses
  localparam logic [2:0] ADDR_MAX_VALUE = 3'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD     = 3'd0,
    KIND_CORRECT    = 3'd1,
    KIND_PERCENTILE = 3'd2,
    KIND_DISTINCT   = 3'd3,
    KIND_NTH        = 3'd4,
    KIND_TOTALS     = 3'd5
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  sample_value;
    logic [VAL_W-1:0]  expected_interval;
    logic [PCT_W-1:0]  percent_centi;
    logic [VAL_W-1:0]  rank_index;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [RES_W-1:0]   result_value;
    logic [RCNT_W-1:0]  result_count;
    logic [TOTAL_W-1:0] total_count;
    logic [VAL_W-1:0]   min_seen;
    logic [VAL_W-1:0]   max_seen;
    logic [WSUM_W-1:0]  weighted_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_SETUP,
    CMD_REC_RD,
    CMD_REC_WR,
    CMD_COR_RD,
    CMD_COR_WR,
    CMD_COR_FIN,
    CMD_DIV,
    CMD_RANK,
    CMD_WALK_RD,
    CMD_WALK_MUL,
    CMD_WALK_ACC
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_REC_RD,
    ST_REC_WR,
    ST_COR_RD,
    ST_COR_WR,
    ST_COR_FIN,
    ST_DIV,
    ST_RANK,
    ST_WALK_RD,
    ST_WALK_MUL,
    ST_WALK_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e kind;
    logic  rec_ok;
    logic  cor_skip;
    logic  walk_empty;
    logic  clr_last;
    logic  div_last;
    logic  cor_last;
    logic  walk_stop;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/lhe_ctrl.sv
// ----------------------------------------------------------------------------
// lhe_ctrl
// Sequencer: clear sweep, item decode, record, correction, division and walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lhe_ctrl import lhe_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output logic         out_load_o,
  output cmd_e         cmd_o,
  input  wire status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LATCH;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o = CMD_SETUP;
        case (status_i.kind)
          KIND_RECORD:     state_d = status_i.rec_ok ? ST_REC_RD : ST_DONE;
          KIND_CORRECT:    state_d = status_i.cor_skip ? ST_DONE : ST_COR_RD;
          KIND_PERCENTILE: state_d = ST_DIV;
          KIND_DISTINCT,
          KIND_NTH,
          KIND_TOTALS:     state_d = status_i.walk_empty ? ST_DONE : ST_WALK_RD;
          default:         state_d = ST_DONE;
        endcase
      end
      ST_REC_RD: begin
        cmd_o   = CMD_REC_RD;
        state_d = ST_REC_WR;
      end
      ST_REC_WR: begin
        cmd_o   = CMD_REC_WR;
        state_d = ST_DONE;
      end
      ST_COR_RD: begin
        cmd_o   = CMD_COR_RD;
        state_d = ST_COR_WR;
      end
      ST_COR_WR: begin
        cmd_o   = CMD_COR_WR;
        state_d = status_i.cor_last ? ST_COR_FIN : ST_COR_RD;
      end
      ST_COR_FIN: begin
        cmd_o   = CMD_COR_FIN;
        state_d = ST_DONE;
      end
      ST_DIV: begin
        cmd_o = CMD_DIV;
        if (status_i.div_last) state_d = ST_RANK;
      end
      ST_RANK: begin
        cmd_o   = CMD_RANK;
        state_d = status_i.walk_empty ? ST_DONE : ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd_o   = CMD_WALK_RD;
        state_d = ST_WALK_MUL;
      end
      ST_WALK_MUL: begin
        cmd_o   = CMD_WALK_MUL;
        state_d = ST_WALK_ACC;
      end
      ST_WALK_ACC: begin
        cmd_o   = CMD_WALK_ACC;
        state_d = status_i.walk_stop ? ST_DONE : ST_WALK_RD;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load_o  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/lhe_datapath.sv
// ----------------------------------------------------------------------------
// lhe_datapath
// Bin and tail memories, totals, divider and walk accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module lhe_datapath import lhe_pkg::*; #(
  parameter int BINS       = 4096,
  parameter int COUNT_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_e             cmd_i,
  input  wire in_item_t         in_item_i,
  input  wire logic [VAL_W-1:0] max_value_i,
  output status_t               status_o,
  output out_item_t             result_o
);

  localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int BW     = COUNT_BITS;
  localparam int TW     = COUNT_BITS + VAL_W;
  localparam int ADD_W  = ((TW > TOTAL_W) ? TW : TOTAL_W) + 1;
  localparam int RS_W   = ((BW > RUN_W) ? BW : RUN_W) + 1;
  localparam int MW     = BW + VAL_W;
  localparam int CW     = (MW > WSUM_W) ? MW : WSUM_W;
  localparam logic [VAL_W-1:0]  LOW_RST  = (BINS - 1 > 4095) ? 12'hFFF : VAL_W'(BINS - 1);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(BINS - 1);

  // storage
  logic [BW-1:0] bin_mem  [BINS];
  logic [TW-1:0] tail_mem [BINS];
  logic [BW-1:0] bin_rdata_q;
  logic [TW-1:0] tail_rdata_q;

  // control state
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [VAL_W-1:0]   lowest_q, lowest_d;
  logic [VAL_W-1:0]   highest_q, highest_d;
  logic [ADDR_W-1:0]  clr_q;

  // per-item working registers
  in_item_t           item_q;
  logic [VAL_W-1:0]   i_q;
  logic               tval_q;
  logic [TOTAL_W-1:0] added_q;
  logic [DIVN_W-1:0]  dq_q;
  logic [DIG_W-1:0]   qd_q;
  logic [PCT_W-1:0]   rem_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [RUN_W-1:0]   rank_q, run_q;
  logic [WSUM_W-1:0]  prod_q, wsum_q;
  logic [RES_W-1:0]   rval_q, seen_q;
  logic [RCNT_W-1:0]  rcnt_q;
  logic               acc_q;

  kind_e            kind;
  logic [VAL_W-1:0] v, e;
  logic [PCT_W-1:0] pct;
  logic [VAL_W:0]   ie_sum;
  logic             hit;

  // memory ports
  logic              bin_re, bin_we, tail_re, tail_we;
  logic [ADDR_W-1:0] bin_raddr, bin_waddr;
  logic [BW-1:0]     bin_wdata;

  // arithmetic
  logic [BW:0]               rec_sum;
  logic [BW-1:0]             rec_sat;
  logic [TW-1:0]             t_add;
  logic [TW:0]               cor_sum;
  logic [BW-1:0]             cor_sat;
  logic [ADD_W-1:0]          add_sum;
  logic [TOTAL_W:0]          tot_sum;
  logic [PROD_W-1:0]         pmul;
  logic [DIVX_W-1:0]         div_x;
  logic [DIVX_W+RECIP_W-1:0] div_mul;
  logic [DIVX_W-1:0]         div_rem;
  logic [RS_W-1:0]           run_sum;
  logic [MW-1:0]             wmul;
  logic [WSUM_W:0]           wsum_sum;
  logic [RCNT_W-1:0]         rcnt_sat;

  assign kind   = kind_e'(item_q.kind);
  assign v      = item_q.sample_value;
  assign e      = item_q.expected_interval;
  assign pct    = (item_q.percent_centi > PCT_FULL) ? PCT_FULL : item_q.percent_centi;
  assign ie_sum = {1'b0, i_q} + {1'b0, e};

  always_comb begin
    bin_re    = (cmd_i == CMD_REC_RD) || (cmd_i == CMD_COR_RD) || (cmd_i == CMD_WALK_RD);
    bin_raddr = (cmd_i == CMD_REC_RD) ? ADDR_W'(v) : ADDR_W'(i_q);
    tail_re   = (cmd_i == CMD_COR_RD);
    tail_we   = (cmd_i == CMD_COR_WR);
    bin_we    = 1'b0;
    bin_waddr = ADDR_W'(i_q);
    bin_wdata = cor_sat;
    case (cmd_i)
      CMD_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_q;
        bin_wdata = '0;
      end
      CMD_REC_WR: begin
        bin_we    = 1'b1;
        bin_waddr = ADDR_W'(v);
        bin_wdata = rec_sat;
      end
      CMD_COR_WR: bin_we = 1'b1;
      default:    bin_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    if (bin_re) bin_rdata_q <= bin_mem[bin_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[ADDR_W'(i_q)] <= cor_sum[TW-1:0];
    if (tail_re) tail_rdata_q <= tail_mem[ADDR_W'(ie_sum)];
  end

  // saturating arithmetic
  always_comb begin
    rec_sum  = {1'b0, bin_rdata_q} + {{BW{1'b0}}, 1'b1};
    rec_sat  = rec_sum[BW] ? '1 : rec_sum[BW-1:0];
    t_add    = tval_q ? tail_rdata_q : '0;
    cor_sum  = {1'b0, TW'(bin_rdata_q)} + {1'b0, t_add};
    cor_sat  = (|cor_sum[TW:BW]) ? '1 : cor_sum[BW-1:0];
    add_sum  = ADD_W'(added_q) + ADD_W'(t_add);
    tot_sum  = {1'b0, total_q} + {1'b0, added_q};
    pmul     = pct * total_q;
    div_x    = {rem_q, dq_q[DIVN_W-1 -: DIG_W]};
    div_mul  = div_x * PCT_RECIP;
    div_rem  = div_x - ({{PCT_W{1'b0}}, qd_q} * DIVX_W'(PCT_FULL));
    run_sum  = RS_W'(run_q) + RS_W'(bin_rdata_q);
    wmul     = bin_rdata_q * i_q;
    wsum_sum = {1'b0, wsum_q} + {1'b0, prod_q};
    rcnt_sat = (64'(bin_rdata_q) > 64'(RCNT_MAX)) ? RCNT_MAX : RCNT_W'(bin_rdata_q);
    hit      = ((kind == KIND_PERCENTILE) && (run_q >= rank_q)) ||
               ((kind == KIND_NTH) && (|bin_rdata_q) && (seen_q == {1'b0, item_q.rank_index}));
  end

  // totals, extremes and clear sweep
  always_comb begin
    total_d   = total_q;
    lowest_d  = lowest_q;
    highest_d = highest_q;
    case (cmd_i)
      CMD_REC_WR: begin
        total_d = (total_q == TOTAL_MAX) ? TOTAL_MAX : total_q + TOTAL_W'(1);
        if (v < lowest_q)  lowest_d  = v;
        if (v > highest_q) highest_d = v;
      end
      CMD_COR_FIN: total_d = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
      default: total_d = total_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      lowest_q  <= LOW_RST;
      highest_q <= '0;
      clr_q     <= '0;
    end else begin
      total_q   <= total_d;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
      if (cmd_i == CMD_CLEAR) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: item_q <= in_item_i;
      CMD_SETUP: begin
        i_q     <= (kind == KIND_CORRECT) ? highest_q : lowest_q;
        added_q <= '0;
        dq_q    <= DIVN_W'(pmul);
        rem_q   <= '0;
        dcnt_q  <= '0;
        run_q   <= '0;
        wsum_q  <= '0;
        rval_q  <= '0;
        rcnt_q  <= '0;
        seen_q  <= '0;
        acc_q   <= 1'b0;
      end
      CMD_REC_WR: acc_q <= 1'b1;
      CMD_COR_RD: tval_q <= ie_sum <= {1'b0, highest_q};
      CMD_COR_WR: begin
        added_q <= (add_sum > ADD_W'(TOTAL_MAX)) ? TOTAL_MAX : add_sum[TOTAL_W-1:0];
        i_q     <= i_q - VAL_W'(1);
      end
      CMD_DIV: begin
        // each quotient digit: reciprocal multiply, then remainder
        if (!dcnt_q[0]) begin
          qd_q <= div_mul[RECIP_SH +: DIG_W];
        end else begin
          rem_q <= div_rem[PCT_W-1:0];
          dq_q  <= {dq_q[DIVN_W-DIG_W-1:0], qd_q};
        end
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      CMD_RANK: rank_q <= dq_q[RUN_W-1:0] + RUN_W'(1);
      CMD_WALK_MUL: begin
        run_q  <= (run_sum > RS_W'({RUN_W{1'b1}})) ? '1 : run_sum[RUN_W-1:0];
        prod_q <= (CW'(wmul) > CW'(WSUM_MAX)) ? WSUM_MAX : WSUM_W'(wmul);
      end
      CMD_WALK_ACC: begin
        i_q <= i_q + VAL_W'(1);
        case (kind)
          KIND_PERCENTILE: if (hit) rval_q <= {1'b0, i_q};
          KIND_DISTINCT:   if (|bin_rdata_q) rval_q <= rval_q + RES_W'(1);
          KIND_NTH: begin
            if (hit) begin
              rval_q <= {1'b0, i_q};
              rcnt_q <= rcnt_sat;
            end else if (|bin_rdata_q) begin
              seen_q <= seen_q + RES_W'(1);
            end
          end
          KIND_TOTALS: wsum_q <= wsum_sum[WSUM_W] ? WSUM_MAX : wsum_sum[WSUM_W-1:0];
          default: rval_q <= rval_q;
        endcase
      end
      default: acc_q <= acc_q;
    endcase
  end

  always_comb begin
    status_o.kind       = kind;
    status_o.rec_ok     = (v <= max_value_i) && (32'(v) < BINS);
    status_o.cor_skip   = (e == '0) || (highest_q <= e);
    status_o.walk_empty = lowest_q > highest_q;
    status_o.clr_last   = clr_q == CLR_LAST;
    status_o.div_last   = dcnt_q == DIV_LAST;
    status_o.cor_last   = {1'b0, i_q} == ({1'b0, e} + (VAL_W+1)'(1));
    status_o.walk_stop  = hit || (i_q == highest_q);
  end

  always_comb begin
    result_o.accepted     = acc_q;
    result_o.result_value = rval_q;
    result_o.result_count = rcnt_q;
    result_o.total_count  = total_q;
    result_o.min_seen     = lowest_q;
    result_o.max_seen     = highest_q;
    result_o.weighted_sum = wsum_q;
  end

endmodule

`default_nettype wire

### hw/rtl/latency_histogram_engine.sv
// ----------------------------------------------------------------------------
// latency_histogram_engine
// Bucketed value histogram with correction and percentile/rank queries.
// ----------------------------------------------------------------------------
// Channel    Handshake            Payload
// in         in_valid/in_ready    in_item_i  (in_item_t)
// out        out_valid/out_ready  out_item_o (out_item_t)
// config     APB write/read       max_value at byte address 0
//
// A record passes accept, decode, bin read, bin write and output load; a
// rejected record, a zero interval or an empty walk skips the bin accesses.
// Correction reads and writes each bin from the largest value down to
// interval+1. Queries read, multiply and accumulate each bin walked from the
// minimum; a percentile first forms its rank by division. After reset a
// clearing pass over all BINS bins runs before the first item.
// The result sits in an output register; a stalled output holds the next
// finished item in its last state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_engine import lhe_pkg::*; #(
  parameter int BINS       = 4096,
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [VAL_W-1:0] max_value_q;
  out_item_t        out_q;
  out_item_t        result;
  cmd_e             cmd;
  status_t          status;
  logic             out_load;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_VALUE) ? {20'b0, max_value_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_MAX_VALUE)) begin
      max_value_q <= pwdata[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= result;
  end

  assign out_item_o = out_q;

  lhe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_load_o  (out_load),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lhe_datapath #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .max_value_i (max_value_q),
    .status_o    (status),
    .result_o    (result)
  );

endmodule

`default_nettype wire
